[src/dsbc_pkg.sv]
// dsbc_pkg: shared types, widths and constants of the disc sector bounds check
// used by every module of the block; no dependencies
`default_nettype none
package dsbc_pkg;

  localparam int RAD_W   = 24;
  localparam int ANG_W   = 16;
  localparam int TOL_W   = 16;
  localparam int CFG_W   = 24;
  localparam int CFG_AW  = 2;
  localparam int IN_W    = 72;
  localparam int OUT_W   = 32;
  localparam int STAGES  = 18;
  localparam int DF_W    = ANG_W + 2;
  localparam int XW      = 56;
  localparam int ZW      = 34;
  localparam int PROD_W  = 54;
  localparam int FRAC    = 28;
  localparam int SCW     = 27;
  localparam int SRW     = 28;
  localparam int MAGW    = 26;
  localparam int SQW     = 54;
  localparam int ROOT_W  = 27;
  localparam int DIST_W  = RAD_W + 1;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [29:0] INV_GAIN = 30'd652032874;

  typedef enum logic [CFG_AW-1:0] {
    REG_INNER  = 2'd0,
    REG_OUTER  = 2'd1,
    REG_CENTER = 2'd2,
    REG_HALF   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                    in_sector;
    logic                    zero;
    logic                    full;
    logic                    pos_df;
    logic signed [DF_W-1:0]  df;
    logic [RAD_W-1:0]        r;
    logic [RAD_W-1:0]        rmin;
    logic [RAD_W-1:0]        rmax;
  } item_t;

  typedef struct packed {
    logic                   in_sector;
    logic                   hyp;
    logic signed [SRW-1:0]  cand;
  } tag_t;

  // atan(2^-i) in 32-bit turns
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] v;
    case (i)
      0: v = 32'd536870912;   1: v = 32'd316933406;  2: v = 32'd167458907;
      3: v = 32'd85004756;    4: v = 32'd42667331;   5: v = 32'd21354465;
      6: v = 32'd10679838;    7: v = 32'd5340245;    8: v = 32'd2670163;
      9: v = 32'd1335087;     10: v = 32'd667544;    11: v = 32'd333772;
      12: v = 32'd166886;     13: v = 32'd83443;     14: v = 32'd41722;
      15: v = 32'd20861;      16: v = 32'd10430;     17: v = 32'd5215;
      18: v = 32'd2608;       19: v = 32'd1304;      20: v = 32'd652;
      21: v = 32'd326;        22: v = 32'd163;       23: v = 32'd81;
      24: v = 32'd41;         25: v = 32'd20;        26: v = 32'd10;
      27: v = 32'd5;          28: v = 32'd3;         29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/dsbc_front.sv]
// dsbc_front: configuration registers, input register and classification
// depends on dsbc_pkg
`default_nettype none
module dsbc_front (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire [dsbc_pkg::IN_W-1:0]     in_tdata,
  input  wire                          cfg_we,
  input  wire [dsbc_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire [dsbc_pkg::CFG_W-1:0]    cfg_wdata,
  output dsbc_pkg::item_t              item,
  output logic                         item_vld,
  input  wire                          item_rdy
);
  import dsbc_pkg::*;

  logic [RAD_W-1:0] inner_r, outer_r;
  logic [ANG_W-1:0] center_r, half_r;
  logic             fr_vld_r;
  item_t            fr_item_r;

  logic [RAD_W-1:0] r, rmin, rmax;
  logic [ANG_W-1:0] ang, d, atol;
  logic [TOL_W-1:0] rtol;
  logic [ANG_W:0]   alpha;
  logic             take;
  item_t            cls;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r  <= '0;
      outer_r  <= '0;
      center_r <= '0;
      half_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_INNER:  inner_r  <= cfg_wdata[RAD_W-1:0];
        REG_OUTER:  outer_r  <= cfg_wdata[RAD_W-1:0];
        REG_CENTER: center_r <= cfg_wdata[ANG_W-1:0];
        REG_HALF:   half_r   <= cfg_wdata[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    r     = in_tdata[23:0];
    ang   = in_tdata[39:24];
    rtol  = in_tdata[55:40];
    atol  = in_tdata[71:56];
    rmin  = (inner_r < outer_r) ? inner_r : outer_r;
    rmax  = (inner_r < outer_r) ? outer_r : inner_r;
    d     = ang - center_r;
    // fold to [0, pi]
    alpha = (d[ANG_W-1] && (|d[ANG_W-2:0])) ? ((ANG_W+1)'(1) << ANG_W) - {1'b0, d}
                                             : {1'b0, d};
    cls.in_sector = (({1'b0, r} + (RAD_W+1)'(rtol)) > {1'b0, rmin})
                 && ({1'b0, r} < ({1'b0, rmax} + (RAD_W+1)'(rtol)))
                 && ({1'b0, alpha} <= ({2'b0, half_r} + {2'b0, atol}));
    cls.zero   = (r == '0);
    cls.full   = half_r[ANG_W-1];
    cls.df     = $signed({1'b0, alpha}) - $signed({2'b0, half_r});
    cls.pos_df = !cls.df[DF_W-1] && (cls.df != '0);
    cls.r      = r;
    cls.rmin   = rmin;
    cls.rmax   = rmax;
  end

  assign in_tready = !fr_vld_r || item_rdy;
  assign take      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else if (in_tready) begin
      fr_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_item_r <= cls;
    end
  end

  assign item     = fr_item_r;
  assign item_vld = fr_vld_r;

endmodule
`default_nettype wire

[src/dsbc_queue.sv]
// dsbc_queue: short transaction queue between front and back
// depends on dsbc_pkg
`default_nettype none
module dsbc_queue (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  dsbc_pkg::item_t  push_item,
  output logic             full,
  input  wire              pop,
  output dsbc_pkg::item_t  pop_item,
  output logic             empty
);
  import dsbc_pkg::*;

  item_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue read while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count out of range");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && pop) |=> $stable(cnt_r))
    else $error("queue count moved on simultaneous push and pop");
`endif

endmodule
`default_nettype wire

[src/dsbc_cordic.sv]
// dsbc_cordic: gain pre-scale, quarter-turn prerotation and rotation stages
// depends on dsbc_pkg
`default_nettype none
module dsbc_cordic (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            en,
  input  wire                            in_vld,
  input  dsbc_pkg::item_t                in_item,
  output logic                           out_vld,
  output dsbc_pkg::item_t                out_item,
  output logic signed [dsbc_pkg::XW-1:0] out_x,
  output logic signed [dsbc_pkg::XW-1:0] out_y
);
  import dsbc_pkg::*;

  localparam logic signed [ZW-1:0] QUARTER = ZW'(64'd1073741824);

  logic              m_vld_r;
  item_t             m_item_r;
  logic [PROD_W-1:0] m_prod_r;

  logic                 vld_r  [0:STAGES];
  item_t                item_r [0:STAGES];
  logic signed [XW-1:0] x_r    [0:STAGES];
  logic signed [XW-1:0] y_r    [0:STAGES];
  logic signed [ZW-1:0] z_r    [0:STAGES];

  logic signed [XW-1:0] x0, px, py;
  logic signed [ZW-1:0] z0, pz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_item_r <= in_item;
      m_prod_r <= PROD_W'(in_item.r) * PROD_W'(INV_GAIN);
    end
  end

  always_comb begin
    x0 = XW'((m_prod_r + PROD_W'(2)) >> 2);
    z0 = ZW'(m_item_r.df) <<< 16;
    if (z0 > QUARTER) begin
      px = '0;
      py = x0;
      pz = z0 - QUARTER;
    end else if (z0 < -QUARTER) begin
      px = '0;
      py = -x0;
      pz = z0 + QUARTER;
    end else begin
      px = x0;
      py = '0;
      pz = z0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r[0] <= m_item_r;
      x_r[0]    <= px;
      y_r[0]    <= py;
      z_r[0]    <= pz;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [ZW-1:0] AT = ZW'(atan_turn(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        item_r[i+1] <= item_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - AT;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + AT;
        end
      end
    end
  end

  assign out_vld  = vld_r[STAGES];
  assign out_item = item_r[STAGES];
  assign out_x    = x_r[STAGES];
  assign out_y    = y_r[STAGES];

endmodule
`default_nettype wire

[src/dsbc_finish.sv]
// dsbc_finish: edge distances, corner hypotenuse (pipelined square root),
// saturation and output register; depends on dsbc_pkg
`default_nettype none
module dsbc_finish (
  input  wire                              clk,
  input  wire                              rst_n,
  output logic                             en,
  input  wire                              in_vld,
  input  dsbc_pkg::item_t                  in_item,
  input  wire signed [dsbc_pkg::XW-1:0]    in_x,
  input  wire signed [dsbc_pkg::XW-1:0]    in_y,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [dsbc_pkg::OUT_W-1:0]       out_tdata
);
  import dsbc_pkg::*;

  localparam logic signed [SRW-1:0] LIM = SRW'((64'd1 << RAD_W) - 64'd1);

  function automatic logic signed [SCW-1:0] rnd(input logic signed [XW-1:0] v);
    logic [XW-1:0] mag, rm;
    mag = v[XW-1] ? XW'(-v) : XW'(v);
    rm  = (mag + (XW'(1) << (FRAC - 1))) >> FRAC;
    return v[XW-1] ? -$signed(SCW'(rm)) : $signed(SCW'(rm));
  endfunction

  logic                  s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  item_t                 s1_item_r, s2_item_r;
  logic signed [SCW-1:0] s1_s_r, s1_c_r, s2_sf_r;
  logic signed [SRW-1:0] s2_sr0_r, s2_sr1_r;
  tag_t                  s3_tag_r, s4_tag_r;
  logic [MAGW-1:0]       s3_a_r, s3_b_r;
  logic [2*MAGW-1:0]     s4_sqa_r, s4_sqb_r;

  logic                  q_vld_r [0:ROOT_W];
  tag_t                  q_tag_r [0:ROOT_W];
  logic [SQW-1:0]        v_r     [0:ROOT_W];
  logic [SQW-1:0]        q_r     [0:ROOT_W];

  logic                  out_vld_r;
  logic [OUT_W-1:0]      out_data_r;

  logic signed [SCW-1:0] sf;
  logic signed [SRW-1:0] rr, sf_x, cand, mx, dsel;
  logic                  hyp;
  logic [MAGW-1:0]       a_mag;
  logic [DIST_W-1:0]     dist_sat;

  assign en = !out_vld_r || out_tready;

  always_comb begin
    sf = s1_item_r.full ? '0 : s1_s_r;
    rr = (!s1_item_r.full && s1_item_r.pos_df) ? SRW'(s1_c_r)
                                               : $signed(SRW'(s1_item_r.r));
  end

  always_comb begin
    sf_x  = SRW'(s2_sf_r);
    hyp   = 1'b0;
    a_mag = '0;
    mx    = (s2_sr0_r > s2_sr1_r) ? s2_sr0_r : s2_sr1_r;
    if (s2_item_r.zero) begin
      cand = $signed(SRW'(s2_item_r.rmin));
    end else if (s2_item_r.full || sf_x <= 0) begin
      if (s2_sr0_r > 0)           cand = s2_sr0_r;
      else if (s2_sr1_r > 0)      cand = s2_sr1_r;
      else if (s2_item_r.full)    cand = mx;
      else                        cand = (sf_x > mx) ? sf_x : mx;
    end else begin
      cand = sf_x;
      if (s2_sr0_r > 0) begin
        hyp   = 1'b1;
        a_mag = MAGW'(s2_sr0_r);
      end else if (s2_sr1_r > 0) begin
        hyp   = 1'b1;
        a_mag = MAGW'(s2_sr1_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
      s4_vld_r   <= 1'b0;
      q_vld_r[0] <= 1'b0;
    end else if (en) begin
      s1_vld_r   <= in_vld;
      s2_vld_r   <= s1_vld_r;
      s3_vld_r   <= s2_vld_r;
      s4_vld_r   <= s3_vld_r;
      q_vld_r[0] <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= in_item;
      s1_s_r    <= rnd(in_y);
      s1_c_r    <= rnd(in_x);
      s2_item_r <= s1_item_r;
      s2_sf_r   <= sf;
      s2_sr0_r  <= $signed(SRW'(s1_item_r.rmin)) - rr;
      s2_sr1_r  <= rr - $signed(SRW'(s1_item_r.rmax));
      s3_tag_r  <= '{in_sector: s2_item_r.in_sector, hyp: hyp, cand: cand};
      s3_a_r    <= a_mag;
      s3_b_r    <= MAGW'(s2_sf_r);
      s4_tag_r  <= s3_tag_r;
      s4_sqa_r  <= (2*MAGW)'(s3_a_r) * (2*MAGW)'(s3_a_r);
      s4_sqb_r  <= (2*MAGW)'(s3_b_r) * (2*MAGW)'(s3_b_r);
      q_tag_r[0] <= s4_tag_r;
      v_r[0]     <= SQW'(s4_sqa_r) + SQW'(s4_sqb_r);
      q_r[0]     <= '0;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * k);
    logic [SQW-1:0] rb;
    assign rb = q_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        q_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        q_vld_r[k+1] <= q_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_tag_r[k+1] <= q_tag_r[k];
        if (v_r[k] >= rb) begin
          v_r[k+1] <= v_r[k] - rb;
          q_r[k+1] <= (q_r[k] >> 1) + BIT;
        end else begin
          v_r[k+1] <= v_r[k];
          q_r[k+1] <= q_r[k] >> 1;
        end
      end
    end
  end

  always_comb begin
    dsel = q_tag_r[ROOT_W].hyp ? $signed({1'b0, q_r[ROOT_W][ROOT_W-1:0]})
                               : q_tag_r[ROOT_W].cand;
    if (dsel > LIM)       dist_sat = DIST_W'(LIM);
    else if (dsel < -LIM) dist_sat = DIST_W'(-LIM);
    else                  dist_sat = DIST_W'(dsel);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= q_vld_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {(OUT_W - DIST_W - 1)'(0), dist_sat, q_tag_r[ROOT_W].in_sector};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

[src/disc_sector_bounds_check_top.sv]
// one transaction per cycle when the output is not stalled; the rate is
// kept through the fully pipelined rotation (18 stages) and the
// one-bit-per-stage square root (27 stages); an output stall holds the back
// while the front keeps filling a four-entry queue
// reset: rst_n synchronous active low, clears valids and all four config registers
`default_nettype none
module disc_sector_bounds_check_top (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // radius[23:0], angle[39:24], radial_tolerance[55:40], angular_tolerance[71:56]
  input  wire [dsbc_pkg::IN_W-1:0]       in_tdata,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // inside_res[0], distance[25:1], zero pad[31:26]
  output logic [dsbc_pkg::OUT_W-1:0]     out_tdata,
  input  wire                            cfg_we,
  input  wire [dsbc_pkg::CFG_AW-1:0]     cfg_addr,
  input  wire [dsbc_pkg::CFG_W-1:0]      cfg_wdata
);
  import dsbc_pkg::*;

  item_t                fr_item, q_item, c_item;
  logic                 fr_vld, q_full, q_empty, pop, en, c_vld;
  logic signed [XW-1:0] c_x, c_y;

  assign pop = en && !q_empty;

  dsbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .item      (fr_item),
    .item_vld  (fr_vld),
    .item_rdy  (!q_full)
  );

  dsbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_vld && !q_full),
    .push_item (fr_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  dsbc_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (pop),
    .in_item  (q_item),
    .out_vld  (c_vld),
    .out_item (c_item),
    .out_x    (c_x),
    .out_y    (c_y)
  );

  dsbc_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_vld     (c_vld),
    .in_item    (c_item),
    .in_x       (c_x),
    .in_y       (c_y),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

[bench/tb_disc_sector_bounds_check_top.sv]
// testbench for disc_sector_bounds_check_top: directed and random polar points
// checked against an in-bench model of the annular sector test; needs dsbc_pkg
`timescale 1ns / 100ps
`default_nettype none

class sector_scoreboard;
  logic [24:0] want_dist[$];
  logic        want_inside[$];
  int          errors;

  function void note_point(logic ins_flag, logic [24:0] dst_val);
    want_inside.push_back(ins_flag);
    want_dist.push_back(dst_val);
  endfunction

  function void check_result(logic [31:0] data);
    logic        ins;
    logic [24:0] dst;
    if (want_dist.size() == 0) begin
      $display("%0t unexpected result %h", $time, data);
      errors++;
      return;
    end
    ins = want_inside.pop_front();
    dst = want_dist.pop_front();
    if (data[0] !== ins) begin
      $display("%0t inside mismatch: expected %0d actual %0d", $time, ins, data[0]);
      errors++;
    end
    if (data[25:1] !== dst) begin
      $display("%0t distance mismatch: expected %0d actual %0d", $time,
               $signed(dst), $signed(data[25:1]));
      errors++;
    end
    if (data[31:26] !== 6'd0) begin
      $display("%0t pad mismatch: expected 0 actual %h", $time, data[31:26]);
      errors++;
    end
  endfunction
endclass

module tb_disc_sector_bounds_check_top;
  import dsbc_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  sector_scoreboard sb = new();
  longint inner_r, outer_r, centre, half_s;
  int send_idle, recv_idle;
  longint cycles;

  disc_sector_bounds_check_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end
  initial cycles = 0;

  // receiver with random stall
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (longint'(1) << (s - 1))) >> s;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint root_floor(longint v);
    longint lo, hi, mid;
    lo = 0;
    hi = 64'd4294967296;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (mid * mid <= v) lo = mid; else hi = mid;
    end
    return lo;
  endfunction

  function automatic void rotate_radius(longint r, longint df, output longint s,
                                        output longint c);
    longint z, x0, x, y, dx, dy;
    z = df * 65536;
    x0 = round_shift(r * 652032874, 2);
    x = x0;
    y = 0;
    if (z > (longint'(1) << 30)) begin
      x = 0; y = x0; z -= longint'(1) << 30;
    end else if (z < -(longint'(1) << 30)) begin
      x = 0; y = -x0; z += longint'(1) << 30;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i));
      end
    end
    s = round_shift(y, FRAC);
    c = round_shift(x, FRAC);
  endfunction

  function automatic longint edge_distance(longint r, longint alpha, longint rmin,
                                           longint rmax);
    longint sf, s, c, sr0, sr1, df;
    bit full;
    sf = 0;
    full = half_s >= 32768;
    if (r == 0) return rmin;
    if (!full) begin
      df = alpha - half_s;
      rotate_radius(r, df, s, c);
      sf = s;
      if (df > 0) r = c;
    end
    sr0 = rmin - r;
    sr1 = r - rmax;
    if (full || sf <= 0) begin
      if (sr0 > 0) return sr0;
      if (sr1 > 0) return sr1;
      if (full) return sr0 > sr1 ? sr0 : sr1;
      if (sf < sr0) sf = sr0;
      if (sf < sr1) sf = sr1;
      return sf;
    end
    if (sr0 > 0) return root_floor(sr0 * sr0 + sf * sf);
    if (sr1 > 0) return root_floor(sr1 * sr1 + sf * sf);
    return sf;
  endfunction

  task automatic predict_point(logic [IN_W-1:0] d);
    longint rmin, rmax, r, rtol, atol, diff, alpha, dst, lim;
    bit ins;
    rmin = inner_r < outer_r ? inner_r : outer_r;
    rmax = inner_r < outer_r ? outer_r : inner_r;
    r = d[23:0];
    rtol = d[55:40];
    atol = d[71:56];
    diff = (longint'(d[39:24]) - centre) & 64'hFFFF;
    alpha = diff > 32768 ? 65536 - diff : diff;
    lim = (longint'(1) << 24) - 1;
    ins = (r + rtol > rmin) && (r < rmax + rtol) && (alpha <= half_s + atol);
    dst = edge_distance(r, alpha, rmin, rmax);
    if (dst > lim) dst = lim;
    if (dst < -lim) dst = -lim;
    sb.note_point(ins, dst[24:0]);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_INNER:  inner_r = val;
      REG_OUTER:  outer_r = val;
      REG_CENTER: centre = val[15:0];
      REG_HALF:   half_s = val[15:0];
    endcase
  endtask

  task automatic send_point(logic [23:0] r, logic [15:0] a, logic [15:0] rt,
                            logic [15:0] at);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {at, rt, a, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_point({at, rt, a, r});
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (sb.want_dist.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_sector(logic [23:0] ri, logic [23:0] ro, logic [15:0] c,
                            logic [15:0] h);
    drain();
    write_reg(REG_INNER, ri);
    write_reg(REG_OUTER, ro);
    write_reg(REG_CENTER, c);
    write_reg(REG_HALF, h);
    cfg_we <= 1'b0;
  endtask

  task automatic random_point;
    logic [23:0] r;
    logic [15:0] a;
    case ($urandom_range(5))
      0: r = $urandom;
      1: r = 0;
      2: r = 24'hFFFFFF - $urandom_range(3);
      default: r = (inner_r + outer_r) / 2 + $signed($urandom_range(8000)) - 4000;
    endcase
    a = $urandom_range(1) ? $urandom : centre + half_s + $urandom_range(4000) - 2000;
    send_point(r, a, $urandom_range(3) == 0 ? $urandom : $urandom_range(2000),
               $urandom_range(3) == 0 ? $urandom_range(32768) : $urandom_range(500));
  endtask

  initial begin
    inner_r = 0; outer_r = 0; centre = 0; half_s = 0;
    send_idle = 22; recv_idle = 47;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed points at reset settings, then a typical sector, a full-turn sector and a zero-width sector
    send_point(24'd0, 16'd0, 16'd0, 16'd0);
    send_point(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'd32768);
    set_sector(24'd25600, 24'd6400, 16'd16384, 16'd4096);
    send_point(24'd0, 16'd16384, 16'd0, 16'd0);
    send_point(24'd12800, 16'd16384, 16'd0, 16'd0);
    send_point(24'd3200, 16'd16384, 16'd100, 16'd0);
    send_point(24'd40000, 16'd16384, 16'd0, 16'd0);
    send_point(24'd12800, 16'd24000, 16'd0, 16'd0);
    send_point(24'd3000, 16'd22000, 16'd0, 16'd0);
    send_point(24'd40000, 16'd22000, 16'd0, 16'd0);
    send_point(24'd12800, 16'd49152, 16'd0, 16'd32768);
    send_point(24'd12800, 16'd60000, 16'd0, 16'd0);
    send_point(24'd6400, 16'd12288, 16'd0, 16'd0);
    send_point(24'd25600, 16'd20480, 16'd0, 16'd0);
    send_point(24'hFFFFFF, 16'd49152, 16'hFFFF, 16'd100);
    set_sector(24'd1000, 24'd90000, 16'hFFFF, 16'd32768);
    send_point(24'd50000, 16'd1234, 16'd0, 16'd0);
    send_point(24'd500, 16'd40000, 16'd600, 16'd0);
    send_point(24'd100000, 16'd0, 16'd0, 16'd0);
    set_sector(24'hFFFFFF, 24'd0, 16'd0, 16'd0);
    send_point(24'd1, 16'd1, 16'd0, 16'd0);
    send_point(24'hFFFFFF, 16'd32768, 16'd0, 16'd0);
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 3) begin
        send_idle = 47; recv_idle = 22;
      end
      if (ph == 5) begin
        send_idle = 0; recv_idle = 0;
      end
      case (ph)
        0: set_sector($urandom_range(50000), $urandom_range(200000), $urandom,
                      $urandom_range(16000));
        1: set_sector(24'hFFFFFF, 24'hFFFFF0, $urandom, 16'd32767);
        2: set_sector(0, 0, 16'hFFFF, 0);
        3: set_sector($urandom, $urandom, $urandom, $urandom_range(32768));
        4: set_sector($urandom_range(5000), $urandom_range(100000), 0, 16'd32768);
        default: set_sector($urandom_range(60000), $urandom_range(300000), $urandom,
                            $urandom_range(30000));
      endcase
      for (int k = 0; k < 100; k++) random_point();
    end
    drain();
    if (sb.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
